[src/rsb_pkg.sv]
// ----------------------------------------------------------------------------
// rsb_pkg: shared types and constants of the run-length sprite line blitter
// Holds the port payload structs, the op format of the internal queue, the
// input kind, image mode and register index codes, and default sizes.
// ----------------------------------------------------------------------------
package rsb_pkg;

    // Default sizes for the top-level parameters
    localparam int LINE_PIXELS_DEF   = 1024;
    localparam int PALETTE_DEPTH_DEF = 65536;
    localparam int MAX_ROWS_DEF      = 1024;

    // Internal queue and output FIFO sizes
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int OUT_DEPTH   = 4;
    localparam int OUT_AW      = $clog2(OUT_DEPTH);
    localparam int OUT_CW      = $clog2(OUT_DEPTH + 1);

    // Input kinds
    localparam logic [1:0] KIND_PAL_WRITE = 2'd0;
    localparam logic [1:0] KIND_LINE_LOAD = 2'd1;
    localparam logic [1:0] KIND_RLE_BYTE  = 2'd2;
    localparam logic [1:0] KIND_SPRITE    = 2'd3;

    // Image modes
    localparam logic [1:0] MODE_COPY  = 2'd0;
    localparam logic [1:0] MODE_REMAP = 2'd1;
    localparam logic [1:0] MODE_GLASS = 2'd2;
    localparam logic [1:0] MODE_BLEND = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] REG_IMAGE_MODE = 2'd0;
    localparam logic [1:0] REG_ZOOM_SHIFT = 2'd1;
    localparam logic [1:0] REG_CLIP_LEFT  = 2'd2;
    localparam logic [1:0] REG_CLIP_WIDTH = 2'd3;

    localparam int CFG_DATA_W = 11;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] address;
        logic [7:0]  value;
    } in_item_t;

    typedef struct packed {
        logic [9:0] dest_row;
        logic [9:0] dest_column;
        logic [7:0] pixel;
        logic       write_valid;
        logic       line_end;
    } out_item_t;

    typedef struct packed {
        logic [1:0]         image_mode;
        logic [1:0]         zoom_shift;
        logic signed [10:0] clip_left;
        logic [10:0]        clip_width;
    } cfg_t;

    typedef enum logic [1:0] {
        OP_PAL,
        OP_LINE,
        OP_DRAW
    } op_kind_t;

    // One classified operation for the back end
    typedef struct packed {
        op_kind_t    kind;
        logic [15:0] addr;   // palette index, or line column
        logic [7:0]  value;  // palette entry, line pixel, or source pixel
        logic [9:0]  row;
        logic        write;  // draw op carries a pixel write
        logic        last;   // draw op completes the line
    } op_t;

endpackage

[src/rsb_ram.sv]
// ----------------------------------------------------------------------------
// rsb_ram: generic simple dual-port RAM
// One write port, one read port, registered read data; a read at the address
// being written returns the old contents.
// ----------------------------------------------------------------------------
module rsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

[src/rsb_front.sv]
// ----------------------------------------------------------------------------
// rsb_front: input parser of the sprite line blitter
// Tracks the chunk header state, clips and samples each data byte, and
// turns accepted transactions into ops for the back end.
// ----------------------------------------------------------------------------
module rsb_front import rsb_pkg::*; #(
    parameter int LINE_PIXELS   = LINE_PIXELS_DEF,
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF,
    parameter int MAX_ROWS      = MAX_ROWS_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_data,
    input  cfg_t     cfg,
    input  logic     q_full,
    output logic     q_push,
    output op_t      q_op
);

    localparam int RW = $clog2(MAX_ROWS);

    typedef enum logic [1:0] {
        PH_SIZE,
        PH_START,
        PH_DATA
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [6:0]         bytes_left_reg, bytes_left_next;
    logic               last_chunk_reg, last_chunk_next;
    logic signed [11:0] column_pos_reg, column_pos_next;
    logic [RW-1:0]      row_count_reg, row_count_next;

    logic        accept;
    logic [10:0] x_low;
    logic [10:0] col;
    logic [10:0] step_mask;
    logic        in_clip;
    logic        line_end;
    logic [6:0]  bytes_dec;
    logic [RW-1:0] row_inc;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        x_low     = column_pos_reg[10:0];
        col       = x_low >> cfg.zoom_shift;
        step_mask = 11'((11'd1 << cfg.zoom_shift) - 11'd1);
        in_clip   = !column_pos_reg[11] && (x_low < cfg.clip_width)
                    && ((x_low & step_mask) == 11'd0)
                    && ({2'b00, col} < 13'(LINE_PIXELS));
        bytes_dec = bytes_left_reg - 7'd1;
        row_inc   = (row_count_reg == RW'(MAX_ROWS - 1)) ? '0 : row_count_reg + 1'b1;

        phase_next      = phase_reg;
        bytes_left_next = bytes_left_reg;
        last_chunk_next = last_chunk_reg;
        column_pos_next = column_pos_reg;
        row_count_next  = row_count_reg;
        line_end        = 1'b0;

        q_push       = 1'b0;
        q_op.kind    = OP_DRAW;
        q_op.addr    = in_data.address;
        q_op.value   = in_data.value;
        q_op.row     = 10'(row_count_reg);
        q_op.write   = 1'b0;
        q_op.last    = 1'b0;

        if (accept)
        begin
            unique case (in_data.kind)
                KIND_PAL_WRITE:
                begin
                    q_op.kind = OP_PAL;
                    q_push    = ({1'b0, in_data.address} < 17'(PALETTE_DEPTH));
                end
                KIND_LINE_LOAD:
                begin
                    q_op.kind = OP_LINE;
                    q_push    = ({1'b0, in_data.address} < 17'(LINE_PIXELS));
                end
                KIND_SPRITE:
                begin
                    phase_next      = PH_SIZE;
                    bytes_left_next = 7'd0;
                    last_chunk_next = 1'b0;
                    column_pos_next = 12'sd0;
                    row_count_next  = '0;
                end
                KIND_RLE_BYTE:
                begin
                    unique case (phase_reg)
                        PH_SIZE:
                        begin
                            bytes_left_next = in_data.value[6:0];
                            last_chunk_next = in_data.value[7];
                            phase_next      = PH_START;
                        end
                        PH_START:
                        begin
                            column_pos_next = $signed({4'b0000, in_data.value})
                                              - $signed({cfg.clip_left[10], cfg.clip_left});
                            if (bytes_left_reg == 7'd0)
                            begin
                                phase_next = PH_SIZE;
                                line_end   = last_chunk_reg;
                            end
                            else
                            begin
                                phase_next = PH_DATA;
                            end
                        end
                        PH_DATA:
                        begin
                            column_pos_next = column_pos_reg + 12'sd1;
                            bytes_left_next = bytes_dec;
                            if (bytes_dec == 7'd0)
                            begin
                                phase_next = PH_SIZE;
                                line_end   = last_chunk_reg;
                            end
                            q_op.write = in_clip;
                            q_op.addr  = {5'b00000, col};
                        end
                        default:
                        begin
                            phase_next = PH_SIZE;
                        end
                    endcase
                    if (line_end)
                    begin
                        row_count_next = row_inc;
                    end
                    q_op.last = line_end;
                    q_push    = q_op.write || line_end;
                end
                default:
                begin
                    q_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_SIZE;
            bytes_left_reg <= 7'd0;
            last_chunk_reg <= 1'b0;
            column_pos_reg <= 12'sd0;
            row_count_reg  <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            bytes_left_reg <= bytes_left_next;
            last_chunk_reg <= last_chunk_next;
            column_pos_reg <= column_pos_next;
            row_count_reg  <= row_count_next;
        end
    end

endmodule

[src/rsb_op_queue.sv]
// ----------------------------------------------------------------------------
// rsb_op_queue: short op queue between parser and back end
// Register FIFO; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module rsb_op_queue import rsb_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  op_t  push_op,
    output logic full,
    input  logic pop,
    output logic valid,
    output op_t  head_op
);

    op_t                 mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] head_reg;
    logic [QUEUE_AW-1:0] tail_reg;
    logic [QUEUE_CW-1:0] count_reg, count_next;

    assign full    = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign valid   = (count_reg != '0);
    assign head_op = mem_reg[head_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                tail_reg <= tail_reg + 1'b1;
            end
            if (pop)
            begin
                head_reg <= head_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[tail_reg] <= push_op;
        end
    end

endmodule

[src/rsb_back.sv]
// ----------------------------------------------------------------------------
// rsb_back: execution pipeline of the sprite line blitter
// Reads the line buffer, looks up the palette, writes back the pixel and
// queues results; issue is credit-gated so the pipeline never stalls.
// ----------------------------------------------------------------------------
module rsb_back import rsb_pkg::*; #(
    parameter int LINE_PIXELS   = LINE_PIXELS_DEF,
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  op_t        q_op,
    output logic       q_pop,
    input  logic [1:0] image_mode,
    output logic       out_valid,
    input  logic       out_ready,
    output out_item_t  out_data
);

    localparam int LW = $clog2(LINE_PIXELS);
    localparam int PW = $clog2(PALETTE_DEPTH);

    logic       s1_valid_reg;
    op_t        s1_op_reg;
    logic       byp_valid_reg, byp_valid_next;
    logic [7:0] byp_data_reg;
    logic       s2_valid_reg;
    op_t        s2_op_reg;
    logic       s2_use_pal_reg;
    logic       s2_pal_ok_reg;

    logic [7:0]    line_rdata;
    logic [7:0]    pal_rdata;
    logic          s2_line_we;
    logic [LW-1:0] line_waddr;
    logic [7:0]    s2_pix;
    logic [7:0]    s1_dst;
    logic [15:0]   pal_index;
    logic          s1_use_pal;
    logic          s1_pal_ok;
    logic          pal_we;
    logic [3:0]    in_flight;

    out_item_t         out_mem_reg [OUT_DEPTH];
    logic [OUT_AW-1:0] out_head_reg;
    logic [OUT_AW-1:0] out_tail_reg;
    logic [OUT_CW-1:0] out_count_reg, out_count_next;
    logic              out_push;
    logic              out_pop;
    out_item_t         result;

    // Issue only when every op in flight still has a slot in the output FIFO
    assign in_flight = {1'b0, out_count_reg} + 4'(s1_valid_reg) + 4'(s2_valid_reg);
    assign q_pop     = q_valid && (in_flight < 4'(OUT_DEPTH));

    always_comb
    begin
        s2_line_we = s2_valid_reg && ((s2_op_reg.kind == OP_LINE)
                     || ((s2_op_reg.kind == OP_DRAW) && s2_op_reg.write));
        line_waddr = s2_op_reg.addr[LW-1:0];
        s2_pix     = s2_op_reg.value;
        if ((s2_op_reg.kind == OP_DRAW) && s2_use_pal_reg)
        begin
            s2_pix = s2_pal_ok_reg ? pal_rdata : 8'd0;
        end

        // Catch a write landing while this op's line read is in progress
        byp_valid_next = s2_line_we && (line_waddr == q_op.addr[LW-1:0]);

        // Newest writer first, then the captured write, then RAM
        if (s2_line_we && (line_waddr == s1_op_reg.addr[LW-1:0]))
        begin
            s1_dst = s2_pix;
        end
        else if (byp_valid_reg)
        begin
            s1_dst = byp_data_reg;
        end
        else
        begin
            s1_dst = line_rdata;
        end

        unique case (image_mode)
            MODE_COPY:  pal_index = {8'd0, s1_op_reg.value};
            MODE_REMAP: pal_index = {8'd0, s1_op_reg.value};
            MODE_GLASS: pal_index = {8'd0, s1_dst};
            MODE_BLEND: pal_index = {s1_op_reg.value - 8'd1, s1_dst};
            default:    pal_index = {8'd0, s1_op_reg.value};
        endcase
        s1_use_pal = (image_mode != MODE_COPY);
        s1_pal_ok  = ({1'b0, pal_index} < 17'(PALETTE_DEPTH));
        pal_we     = s1_valid_reg && (s1_op_reg.kind == OP_PAL);
    end

    rsb_ram #(
        .WIDTH (8),
        .DEPTH (LINE_PIXELS)
    ) u_line_ram (
        .clk   (clk),
        .we    (s2_line_we),
        .waddr (line_waddr),
        .wdata (s2_pix),
        .raddr (q_op.addr[LW-1:0]),
        .rdata (line_rdata)
    );

    rsb_ram #(
        .WIDTH (8),
        .DEPTH (PALETTE_DEPTH)
    ) u_pal_ram (
        .clk   (clk),
        .we    (pal_we),
        .waddr (s1_op_reg.addr[PW-1:0]),
        .wdata (s1_op_reg.value),
        .raddr (pal_index[PW-1:0]),
        .rdata (pal_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            byp_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= q_pop;
            s2_valid_reg  <= s1_valid_reg;
            byp_valid_reg <= byp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_op_reg      <= q_op;
        byp_data_reg   <= s2_pix;
        s2_op_reg      <= s1_op_reg;
        s2_use_pal_reg <= s1_use_pal;
        s2_pal_ok_reg  <= s1_pal_ok;
    end

    // Result FIFO
    always_comb
    begin
        out_push           = s2_valid_reg && (s2_op_reg.kind == OP_DRAW);
        out_pop            = out_valid && out_ready;
        result.dest_row    = s2_op_reg.row;
        result.dest_column = s2_op_reg.write ? s2_op_reg.addr[9:0] : 10'd0;
        result.pixel       = s2_op_reg.write ? s2_pix : 8'd0;
        result.write_valid = s2_op_reg.write;
        result.line_end    = s2_op_reg.last;

        out_count_next = out_count_reg;
        if (out_push && !out_pop)
        begin
            out_count_next = out_count_reg + 1'b1;
        end
        else if (out_pop && !out_push)
        begin
            out_count_next = out_count_reg - 1'b1;
        end
    end

    assign out_valid = (out_count_reg != '0);
    assign out_data  = out_mem_reg[out_head_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_head_reg  <= '0;
            out_tail_reg  <= '0;
            out_count_reg <= '0;
        end
        else
        begin
            if (out_push)
            begin
                out_tail_reg <= out_tail_reg + 1'b1;
            end
            if (out_pop)
            begin
                out_head_reg <= out_head_reg + 1'b1;
            end
            out_count_reg <= out_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_push)
        begin
            out_mem_reg[out_tail_reg] <= result;
        end
    end

endmodule

[src/rle_sprite_line_blitter.sv]
// ----------------------------------------------------------------------------
// rle_sprite_line_blitter: run-length sprite line decoder with palette remap
// Throughput: one transaction per cycle while the op queue has room, set by the one-op-per-cycle back end.
// Path: an accepted byte's op passes the op queue, the line read, the palette
// read and the result FIFO before its result can be taken.
// Reset: clears parser, queue, pipeline and registers; stores are not cleared.
// ----------------------------------------------------------------------------
module rle_sprite_line_blitter import rsb_pkg::*; #(
    parameter int LINE_PIXELS   = LINE_PIXELS_DEF,
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF,
    parameter int MAX_ROWS      = MAX_ROWS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data,
    input  logic                  cfg_write,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // The front end takes one transaction per cycle whenever the op queue has
    // room. Palette writes and line loads become ops directly; run-length
    // bytes walk the chunk header state, and data bytes are clipped and
    // sampled here so that only drawn pixels and line ends reach the back.
    //
    // The back end runs a two-stage pipeline: stage one holds the line
    // buffer read data (with bypass from a write in flight) and issues the
    // palette read or write; stage two forms the pixel, writes it back to the
    // line buffer and pushes the result. Issue is gated by free slots in the
    // result FIFO, so a stalled consumer backs up into the op queue and then
    // into in_ready, while the pipeline itself never holds.

    cfg_t cfg_reg;

    logic q_full;
    logic q_push;
    op_t  q_push_op;
    logic q_valid;
    logic q_pop;
    op_t  q_head_op;

    // Hold configuration; decode the write index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_IMAGE_MODE: cfg_reg.image_mode <= cfg_data[1:0];
                REG_ZOOM_SHIFT: cfg_reg.zoom_shift <= cfg_data[1:0];
                REG_CLIP_LEFT:  cfg_reg.clip_left  <= $signed(cfg_data[10:0]);
                REG_CLIP_WIDTH: cfg_reg.clip_width <= cfg_data[10:0];
                default:        cfg_reg.image_mode <= cfg_reg.image_mode;
            endcase
        end
    end

    rsb_front #(
        .LINE_PIXELS   (LINE_PIXELS),
        .PALETTE_DEPTH (PALETTE_DEPTH),
        .MAX_ROWS      (MAX_ROWS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .cfg      (cfg_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_op     (q_push_op)
    );

    rsb_op_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .push_op (q_push_op),
        .full    (q_full),
        .pop     (q_pop),
        .valid   (q_valid),
        .head_op (q_head_op)
    );

    rsb_back #(
        .LINE_PIXELS   (LINE_PIXELS),
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_op       (q_head_op),
        .q_pop      (q_pop),
        .image_mode (cfg_reg.image_mode),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule
